// File: hdl/gtlw_pkg.sv
// ----------------------------------------------------------------------------
// gtlw_pkg: shared types and constants of the greedy text line wrapper
// Item, work and result records, configuration record, sequencer states,
// character codes and helper saturation functions.
// ----------------------------------------------------------------------------
package gtlw_pkg;

	// character codes
	localparam logic [20:0] CODE_SPACE   = 21'd32;
	localparam logic [20:0] CODE_NEWLINE = 21'd10;

	// configuration register indexes
	localparam int          CFG_IDX_W      = 2;
	localparam int          CFG_DATA_W     = 17;
	localparam logic [1:0]  CFG_MAX_WIDTH  = 2'd0;
	localparam logic [1:0]  CFG_MAX_HEIGHT = 2'd1;
	localparam logic [1:0]  CFG_LINE_HEIGHT = 2'd2;

	// limits
	localparam int          RESCAN_DEPTH_DEF = 64;
	localparam logic [15:0] MAX_TEXT_CHARS   = 16'd65535;
	localparam int          OUT_SLOTS        = 64;
	localparam int          CNT_W            = $clog2(OUT_SLOTS + 1);
	localparam int          FRONT_Q_DEPTH    = 2;

	// classified input character
	typedef struct packed {
		logic              is_space;
		logic              is_nl;
		logic              glyph;
		logic [9:0]        adv;
		logic signed [8:0] kern;
		logic              last;
	} gtlw_char_t;

	// character with its text index, as processed and buffered for rescan
	typedef struct packed {
		logic              is_space;
		logic              is_nl;
		logic              glyph;
		logic [9:0]        adv;
		logic signed [8:0] kern;
		logic              last;
		logic [15:0]       idx;
	} gtlw_work_t;

	// one line result
	typedef struct packed {
		logic [15:0] line_start;
		logic [15:0] line_length;
		logic [15:0] line_width;
		logic        final_line;
		logic        stopped_early;
		logic [15:0] total_height;
		logic [15:0] widest_line;
		logic        buffer_overflow;
	} gtlw_result_t;

	// configuration registers
	typedef struct packed {
		logic signed [16:0] max_width;
		logic signed [16:0] max_height;
		logic [9:0]         line_height;
	} gtlw_cfg_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_FETCH,
		ST_LOAD
	} gtlw_state_t;

	// clamp an 18-bit signed sum to -65536..65535
	function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
		logic signed [16:0] r;
		if (v > 18'sd65535) begin
			r = 17'sd65535;
		end else if (v < -18'sd65536) begin
			r = -17'sd65536;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

	// clamp an unsigned product to 16 bits
	function automatic logic [15:0] sat16u(input logic [26:0] v);
		logic [15:0] r;
		if (|v[26:16]) begin
			r = 16'hFFFF;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/gtlw_ram.sv
// ----------------------------------------------------------------------------
// gtlw_ram: generic single write port RAM with registered read
// One write and one read address per cycle; read data is registered and follows the read address.
// ----------------------------------------------------------------------------
module gtlw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/gtlw_front.sv
// ----------------------------------------------------------------------------
// gtlw_front: request intake and classification
// Accepts character requests, marks spaces and newlines and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module gtlw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [20:0]           char_code,
	input  logic                  has_glyph,
	input  logic [9:0]            advance,
	input  logic signed [8:0]     pair_kerning,
	input  logic                  last_char,
	input  logic                  pop,
	output logic                  pop_valid,
	output gtlw_pkg::gtlw_char_t  pop_item
);
	import gtlw_pkg::*;

	localparam int PTR_W = $clog2(FRONT_Q_DEPTH);
	localparam int CNT_QW = $clog2(FRONT_Q_DEPTH + 1);

	gtlw_char_t        entry_q [FRONT_Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	gtlw_char_t        item;
	logic              push;
	logic              take;

	// classify the request
	always_comb begin
		item.is_space = (char_code == CODE_SPACE);
		item.is_nl    = (char_code == CODE_NEWLINE);
		item.glyph    = has_glyph;
		item.adv      = advance;
		item.kern     = pair_kerning;
		item.last     = last_char;
	end

	assign in_stall  = (count_q == CNT_QW'(FRONT_Q_DEPTH));
	assign push      = in_valid && !in_stall;
	assign pop_valid = (count_q != '0);
	assign take      = pop && pop_valid;
	assign pop_item  = entry_q[rd_ptr_q];

	// store the request
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	// advance the queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FRONT_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FRONT_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/gtlw_back.sv
// ----------------------------------------------------------------------------
// gtlw_back: line breaking engine
// Measures characters, breaks lines, replays the word after a space break
// from the rescan buffer and drives the result register.
// ----------------------------------------------------------------------------
module gtlw_back #(
	parameter int RESCAN_DEPTH = gtlw_pkg::RESCAN_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gtlw_pkg::gtlw_cfg_t   cfg,
	input  logic                  pop_valid,
	input  gtlw_pkg::gtlw_char_t  pop_item,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output gtlw_pkg::gtlw_result_t out_res
);
	import gtlw_pkg::*;

	localparam int PW = $clog2(RESCAN_DEPTH + 1);
	localparam int AW = $clog2(RESCAN_DEPTH);
	localparam int WW = $bits(gtlw_work_t);

	// sequencer and step registers
	gtlw_state_t        state_q, state_d;
	gtlw_work_t         cur_q, cur_d;
	logic               step_last_q, step_last_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [PW-1:0]      rptr_q, rptr_d;
	logic [PW-1:0]      rcount_q, rcount_d;
	// text registers
	logic signed [16:0] cur_w_q, cur_w_d;
	logic               lsv_q, lsv_d;
	logic [15:0]        lsi_q, lsi_d;
	logic signed [16:0] lsw_q, lsw_d;
	logic [15:0]        lss_q, lss_d;
	logic [15:0]        char_idx_q, char_idx_d;
	logic [15:0]        lc_q, lc_d;
	logic [15:0]        widest_q, widest_d;
	logic               als_q, als_d;
	logic               halted_q, halted_d;
	logic               ovf_q, ovf_d;
	logic [PW-1:0]      pend_q, pend_d;
	// result register
	logic               out_valid_q;
	gtlw_result_t       out_q;
	logic               emit;
	gtlw_result_t       res;
	logic               out_free;
	logic               do_reset;

	// rescan buffer port
	logic               ram_we;
	logic [WW-1:0]      ram_rdata;

	// evaluation of the current character
	logic               sp, nl, skip, use_g;
	logic               lsv_e;
	logic [15:0]        lsi_e;
	logic signed [16:0] lsw_e;
	logic               pend_full, wr_e, ovf_e;
	logic [PW-1:0]      pend_e;
	logic               als_e;
	logic signed [11:0] cw;
	logic signed [17:0] sum;
	logic               too_long, hit0, brk, sb, fin, swallow;
	logic [15:0]        bp, len;
	logic signed [16:0] bw;
	logic [15:0]        wclamp, widest_new;
	logic [16:0]        lc_inc;
	logic [26:0]        prod1, prod0;
	logic               h_over, slot_full, need_emit, more;

	gtlw_ram #(
		.WIDTH(WW),
		.DEPTH(RESCAN_DEPTH)
	) u_rescan (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pend_q[AW-1:0]),
		.wdata(cur_q),
		.raddr(rptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// height product, shared by the limit check and the reported height
	assign lc_inc = {1'b0, lc_q} + 17'd1;
	assign prod1  = {10'd0, lc_inc} * {17'd0, cfg.line_height};
	assign prod0  = prod1 - {17'd0, cfg.line_height};

	// measure the current character
	always_comb begin
		sp    = cur_q.is_space;
		nl    = cur_q.is_nl;
		lsv_e = sp ? 1'b1 : lsv_q;
		lsi_e = sp ? cur_q.idx : lsi_q;
		lsw_e = sp ? cur_w_q : lsw_q;
		pend_full = (pend_q >= PW'(RESCAN_DEPTH));
		wr_e  = !sp && !pend_full;
		ovf_e = ovf_q || (!sp && pend_full);
		if (sp) begin
			pend_e = '0;
		end else if (!pend_full) begin
			pend_e = pend_q + 1'b1;
		end else begin
			pend_e = pend_q;
		end
		skip  = !nl && !cur_q.glyph && !cur_q.last;
		use_g = !nl && cur_q.glyph;
		als_e = use_g ? 1'b1 : als_q;
		if (use_g) begin
			cw = $signed({2'b00, cur_q.adv})
				+ (als_q ? $signed({{3{cur_q.kern[8]}}, cur_q.kern}) : 12'sd0);
		end else begin
			cw = 12'sd0;
		end
		sum      = $signed({cur_w_q[16], cur_w_q}) + $signed({{6{cw[11]}}, cw});
		too_long = !cfg.max_width[16] && (sum > $signed({cfg.max_width[16], cfg.max_width}));
		hit0     = too_long && (cur_w_q == 17'sd0);
		brk      = nl || cur_q.last || too_long;
		sb       = lsv_e && too_long;
		fin      = !sb && cur_q.last;
		swallow  = !sb && nl;
		bp       = sb ? lsi_e : cur_q.idx + {15'd0, fin};
		if (sb) begin
			bw = lsw_e;
		end else if (fin) begin
			bw = sat17(sum);
		end else begin
			bw = cur_w_q;
		end
		len        = (bp >= lss_q) ? bp - lss_q : 16'd0;
		wclamp     = bw[16] ? 16'd0 : bw[15:0];
		widest_new = (wclamp > widest_q) ? wclamp : widest_q;
		h_over     = !cfg.max_height[16] && (prod1 > {11'd0, cfg.max_height[15:0]});
		slot_full  = !fin && (cnt_q >= CNT_W'(OUT_SLOTS - 1));
		need_emit  = !skip && (hit0 || brk);
		more       = (rptr_q < rcount_q);
	end

	// next state and outputs of the sequencer
	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		step_last_d = step_last_q;
		cnt_d       = cnt_q;
		rptr_d      = rptr_q;
		rcount_d    = rcount_q;
		cur_w_d     = cur_w_q;
		lsv_d       = lsv_q;
		lsi_d       = lsi_q;
		lsw_d       = lsw_q;
		lss_d       = lss_q;
		char_idx_d  = char_idx_q;
		lc_d        = lc_q;
		widest_d    = widest_q;
		als_d       = als_q;
		halted_d    = halted_q;
		ovf_d       = ovf_q;
		pend_d      = pend_q;
		pop         = 1'b0;
		emit        = 1'b0;
		ram_we      = 1'b0;
		do_reset    = 1'b0;
		res         = '0;

		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					if (halted_q) begin
						// drop requests until the text ends
						pop = 1'b1;
						do_reset = pop_item.last;
					end else if (char_idx_q >= MAX_TEXT_CHARS) begin
						// text too long: stop
						if (out_free) begin
							pop  = 1'b1;
							emit = 1'b1;
							res.line_start      = lss_q;
							res.final_line      = 1'b1;
							res.stopped_early   = 1'b1;
							res.total_height    = sat16u(prod0);
							res.widest_line     = widest_q;
							res.buffer_overflow = ovf_q;
							if (pop_item.last) begin
								do_reset = 1'b1;
							end else begin
								halted_d = 1'b1;
							end
						end
					end else begin
						// start a step with a fresh character
						pop = 1'b1;
						cur_d.is_space = pop_item.is_space;
						cur_d.is_nl    = pop_item.is_nl;
						cur_d.glyph    = pop_item.glyph;
						cur_d.adv      = pop_item.adv;
						cur_d.kern     = pop_item.kern;
						cur_d.last     = pop_item.last;
						cur_d.idx      = char_idx_q;
						char_idx_d  = char_idx_q + 16'd1;
						step_last_d = pop_item.last;
						cnt_d       = '0;
						rptr_d      = '0;
						rcount_d    = '0;
						state_d     = ST_PROC;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cur_d   = gtlw_work_t'(ram_rdata);
				rptr_d  = rptr_q + 1'b1;
				state_d = ST_PROC;
			end
			ST_PROC: begin
				if (!need_emit || out_free) begin
					// buffer bookkeeping
					ram_we = wr_e;
					lsv_d  = lsv_e;
					lsi_d  = lsi_e;
					lsw_d  = lsw_e;
					pend_d = pend_e;
					ovf_d  = ovf_e;
					als_d  = als_e;
					res.line_start      = lss_q;
					res.buffer_overflow = ovf_e;
					if (skip) begin
						state_d = more ? ST_FETCH : ST_IDLE;
					end else if (hit0 || (brk && (h_over || slot_full))) begin
						// stop on a limit
						emit = 1'b1;
						cnt_d = cnt_q + 1'b1;
						res.final_line    = 1'b1;
						res.stopped_early = 1'b1;
						res.total_height  = sat16u(prod0);
						res.widest_line   = widest_q;
						if (step_last_q) begin
							do_reset = 1'b1;
						end else begin
							halted_d = 1'b1;
						end
						state_d = ST_IDLE;
					end else if (!brk) begin
						// extend the line
						cur_w_d = sat17(sum);
						state_d = more ? ST_FETCH : ST_IDLE;
					end else begin
						// close the line
						emit = 1'b1;
						cnt_d = cnt_q + 1'b1;
						res.line_length  = len;
						res.line_width   = wclamp;
						res.final_line   = fin;
						res.total_height = sat16u(prod1);
						res.widest_line  = widest_new;
						lc_d     = (lc_q == 16'hFFFF) ? lc_q : lc_q + 16'd1;
						widest_d = widest_new;
						if (fin) begin
							do_reset = 1'b1;
							state_d  = ST_IDLE;
						end else begin
							cur_w_d = '0;
							als_d   = 1'b0;
							lsv_d   = 1'b0;
							lsw_d   = '0;
							lss_d   = bp + {15'd0, sb || swallow};
							pend_d  = '0;
							if (sb) begin
								// replay the word after the space
								rcount_d = pend_e;
								rptr_d   = '0;
								state_d  = (pend_e != '0) ? ST_FETCH : ST_IDLE;
							end else if (too_long && !swallow) begin
								state_d = ST_PROC;
							end else begin
								state_d = more ? ST_FETCH : ST_IDLE;
							end
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// end of text: clear the text state
		if (do_reset) begin
			cur_w_d    = '0;
			lsv_d      = 1'b0;
			lsi_d      = '0;
			lsw_d      = '0;
			lss_d      = '0;
			char_idx_d = '0;
			lc_d       = '0;
			widest_d   = '0;
			als_d      = 1'b0;
			halted_d   = 1'b0;
			ovf_d      = 1'b0;
			pend_d     = '0;
		end
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_last_q <= 1'b0;
			cnt_q       <= '0;
			rptr_q      <= '0;
			rcount_q    <= '0;
			cur_w_q     <= '0;
			lsv_q       <= 1'b0;
			lsi_q       <= '0;
			lsw_q       <= '0;
			lss_q       <= '0;
			char_idx_q  <= '0;
			lc_q        <= '0;
			widest_q    <= '0;
			als_q       <= 1'b0;
			halted_q    <= 1'b0;
			ovf_q       <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_last_q <= step_last_d;
			cnt_q       <= cnt_d;
			rptr_q      <= rptr_d;
			rcount_q    <= rcount_d;
			cur_w_q     <= cur_w_d;
			lsv_q       <= lsv_d;
			lsi_q       <= lsi_d;
			lsw_q       <= lsw_d;
			lss_q       <= lss_d;
			char_idx_q  <= char_idx_d;
			lc_q        <= lc_d;
			widest_q    <= widest_d;
			als_q       <= als_d;
			halted_q    <= halted_d;
			ovf_q       <= ovf_d;
			pend_q      <= pend_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

// File: hdl/greedy_text_line_wrapper_top.sv
// ----------------------------------------------------------------------------
// greedy_text_line_wrapper_top: greedy text line wrapper
// Breaks a character stream into lines at newlines, text end and width
// overflow, going back to the last space; one result per line.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | in_valid / in_stall     | char_code has_glyph advance
//           |                         | pair_kerning last_char
//  output   | out_valid / out_stall   | line_start line_length line_width
//           |                         | final_line stopped_early total_height
//           |                         | widest_line buffer_overflow
//  config   | cfg_we                  | cfg_index cfg_data
//
//  A fresh character is dequeued by the engine, then measured. A character
//  replayed after a space break is read from the rescan RAM, loaded, then
//  measured; a width break without a space measures its character again.
//  A two-entry queue parts intake from the engine; the engine holds on a
//  line break while the result register is full and out_stall is high.
//  No clearing pass after reset; the rescan RAM is only read where written.
// ----------------------------------------------------------------------------
module greedy_text_line_wrapper_top #(
	parameter int RESCAN_DEPTH = gtlw_pkg::RESCAN_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [20:0]                     char_code,
	input  logic                            has_glyph,
	input  logic [9:0]                      advance,
	input  logic signed [8:0]               pair_kerning,
	input  logic                            last_char,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     line_start,
	output logic [15:0]                     line_length,
	output logic [15:0]                     line_width,
	output logic                            final_line,
	output logic                            stopped_early,
	output logic [15:0]                     total_height,
	output logic [15:0]                     widest_line,
	output logic                            buffer_overflow,
	input  logic                            cfg_we,
	input  logic [gtlw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gtlw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gtlw_pkg::*;

	gtlw_cfg_t    cfg_q;
	logic         pop;
	logic         pop_valid;
	gtlw_char_t   pop_item;
	gtlw_result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_width   <= -17'sd1;
			cfg_q.max_height  <= -17'sd1;
			cfg_q.line_height <= 10'd14;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_WIDTH:   cfg_q.max_width   <= $signed(cfg_data);
				CFG_MAX_HEIGHT:  cfg_q.max_height  <= $signed(cfg_data);
				CFG_LINE_HEIGHT: cfg_q.line_height <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	gtlw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.has_glyph   (has_glyph),
		.advance     (advance),
		.pair_kerning(pair_kerning),
		.last_char   (last_char),
		.pop         (pop),
		.pop_valid   (pop_valid),
		.pop_item    (pop_item)
	);

	gtlw_back #(
		.RESCAN_DEPTH(RESCAN_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop_item (pop_item),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_res  (res)
	);

	// unpack the result
	assign line_start      = res.line_start;
	assign line_length     = res.line_length;
	assign line_width      = res.line_width;
	assign final_line      = res.final_line;
	assign stopped_early   = res.stopped_early;
	assign total_height    = res.total_height;
	assign widest_line     = res.widest_line;
	assign buffer_overflow = res.buffer_overflow;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: greedy text line wrapper testbench
// Drives character requests with random gaps, predicts each line result in a
// local model of the greedy wrapper and compares every field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import gtlw_pkg::*;

	localparam int RSC_DEPTH = 64;
	localparam int TEXT_LIMIT = 65535;

	// one character as the wrapper sees it
	typedef struct {
		logic [20:0] code;
		bit          glyph;
		int          adv;
		int          kern;
		bit          last;
		int          idx;
	} wchar_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [20:0]           char_code;
	logic                  has_glyph;
	logic [9:0]            advance;
	logic signed [8:0]     pair_kerning;
	logic                  last_char;
	logic                  out_valid;
	logic                  out_stall;
	logic [15:0]           line_start;
	logic [15:0]           line_length;
	logic [15:0]           line_width;
	logic                  final_line;
	logic                  stopped_early;
	logic [15:0]           total_height;
	logic [15:0]           widest_line;
	logic                  buffer_overflow;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	greedy_text_line_wrapper_top dut (.*);

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// predictor state
	int     lim_width, lim_height, lh;
	int     cur_w, sp_idx, sp_w, ln_start, ch_idx, ln_cnt, widest;
	bit     after_start, halted, ovf;
	wchar_t pend[$];
	wchar_t work[$];
	gtlw_result_t expected_lines[$];
	int     fails;
	int     hold_cycles;
	int     rx_wait;
	bit     stall_rand;

	function automatic int sat17i(int v);
		if (v > 65535) return 65535;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic int height_now();
		longint t;
		t = longint'(ln_cnt) * lh;
		return (t > 65535) ? 65535 : int'(t);
	endfunction

	function automatic void clear_text();
		cur_w = 0; sp_idx = -1; sp_w = 0; ln_start = 0; ch_idx = 0;
		ln_cnt = 0; widest = 0; after_start = 0; halted = 0; ovf = 0;
		pend.delete();
	endfunction

	function automatic void push_line(int st, int len, int w, bit fin, bit stp);
		gtlw_result_t r;
		r.line_start = st[15:0];
		r.line_length = len[15:0];
		r.line_width = w[15:0];
		r.final_line = fin;
		r.stopped_early = stp;
		r.total_height = 16'(height_now());
		r.widest_line = widest[15:0];
		r.buffer_overflow = ovf;
		expected_lines = {expected_lines, r};
	endfunction

	function automatic void stop_text();
		push_line(ln_start, 0, 0, 1, 1);
		halted = 1;
		work.delete();
	endfunction

	// measure one character; return 1 when the final line of the text closes
	function automatic bit measure(wchar_t c, ref int nres);
		int cw, bp, bw, len, wc;
		bit too_long, sbrk, swallow, fin;
		wchar_t saved[$];
		cw = 0; swallow = 0; fin = 0;
		if (c.code == CODE_SPACE) begin
			sp_idx = c.idx; sp_w = cur_w; pend.delete();
		end else if (pend.size() < RSC_DEPTH) begin
			pend = {pend, c};
		end else begin
			ovf = 1;
		end
		if (c.code != CODE_NEWLINE) begin
			if (!c.glyph) begin
				if (!c.last) return 0;
			end else begin
				cw = c.adv + (after_start ? c.kern : 0);
				after_start = 1;
			end
		end
		too_long = lim_width >= 0 && cur_w + cw > lim_width;
		if (too_long && cur_w == 0) begin
			stop_text(); nres++; return 0;
		end
		if (!(c.code == CODE_NEWLINE || c.last || too_long)) begin
			cur_w = sat17i(cur_w + cw);
			return 0;
		end
		sbrk = sp_idx >= 0 && too_long;
		if (sbrk) begin
			bp = sp_idx; bw = sp_w;
		end else begin
			bp = c.idx; bw = cur_w;
			swallow = (c.code == CODE_NEWLINE);
			if (c.last) begin
				bp++; bw = sat17i(bw + cw); fin = 1;
			end
		end
		if (lim_height >= 0 && longint'(ln_cnt + 1) * lh > lim_height) begin
			stop_text(); nres++; return 0;
		end
		if (!fin && nres >= OUT_SLOTS - 1) begin
			stop_text(); nres++; return 0;
		end
		len = (bp >= ln_start) ? bp - ln_start : 0;
		wc = (bw < 0) ? 0 : bw;
		if (ln_cnt < 65535) ln_cnt++;
		if (wc > widest) widest = wc;
		push_line(ln_start, len, wc, fin, 0);
		nres++;
		if (fin) begin
			clear_text(); return 1;
		end
		cur_w = 0; after_start = 0; sp_idx = -1; sp_w = 0;
		ln_start = bp + ((sbrk || swallow) ? 1 : 0);
		if (sbrk) begin
			saved = pend;
			pend.delete();
			work = {saved, work};
			while (work.size() > RSC_DEPTH + 1) void'(work.pop_back());
		end else if (too_long && !swallow) begin
			pend.delete();
			work.push_front(c);
			while (work.size() > RSC_DEPTH + 1) void'(work.pop_back());
		end else begin
			pend.delete();
		end
		return 0;
	endfunction

	// predict the lines caused by one character request
	function automatic void predict_char(logic [20:0] code, bit g, int adv, int kern,
			bit last);
		wchar_t c;
		int nres;
		nres = 0;
		if (halted) begin
			if (last) clear_text();
			return;
		end
		if (ch_idx >= TEXT_LIMIT) begin
			stop_text();
			if (last) clear_text();
			return;
		end
		c.code = code; c.glyph = g; c.adv = adv; c.kern = kern; c.last = last;
		c.idx = ch_idx;
		ch_idx++;
		work.delete();
		work = {c};
		while (work.size() > 0 && !halted) begin
			c = work.pop_front();
			if (measure(c, nres)) break;
		end
		work.delete();
		if (halted && last) clear_text();
	endfunction

	// send one character request and predict it; valid stays high on return
	task automatic send_char(logic [20:0] code, bit g, int adv, int kern, bit last);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= code;
		has_glyph <= g;
		advance <= adv[9:0];
		pair_kerning <= kern[8:0];
		last_char <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_char(code, g, adv, kern, last);
		@(negedge clk);
	endtask

	// drop valid and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[16:0];
		@(negedge clk);
		case (idx)
			CFG_MAX_WIDTH: lim_width = val;
			CFG_MAX_HEIGHT: lim_height = val;
			default: lh = val;
		endcase
	endtask

	task automatic set_limits(int w, int h, int l);
		drain();
		write_reg(CFG_MAX_WIDTH, w);
		write_reg(CFG_MAX_HEIGHT, h);
		write_reg(CFG_LINE_HEIGHT, l);
		cfg_we <= 1'b0;
	endtask

	// random character: mostly letters, some spaces and newlines
	task automatic send_random(bit last);
		int r;
		logic [20:0] code;
		r = $urandom_range(0, 19);
		if (r < 3) code = CODE_SPACE;
		else if (r == 3) code = CODE_NEWLINE;
		else if (r == 4) code = $urandom_range(0, 21'h1FFFFF);
		else code = $urandom_range(65, 122);
		send_char(code, $urandom_range(0, 9) != 0,
			($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12),
			($urandom_range(0, 7) == 0) ? $signed($urandom_range(0, 511)) - 256
				: $signed($urandom_range(0, 4)) - 2, last);
	endtask

	task automatic send_text(int n);
		for (int i = 0; i < n; i++) send_random(i == n - 1);
	endtask

	// extremes of every field with no limits
	task automatic test_fields();
		send_char(21'h1FFFFF, 1, 1023, 255, 0);
		send_char(21'd0, 1, 0, -256, 0);
		send_char(21'd65, 0, 1023, 255, 0);
		send_char(CODE_NEWLINE, 1, 5, 3, 0);
		send_char(CODE_NEWLINE, 0, 0, 0, 1);
		send_char(21'd66, 0, 7, 0, 1);
		send_char(21'd67, 1, 10, -100, 0);
		send_char(21'd68, 1, 0, -256, 1);
	endtask

	// space break, rescan, single-char overflow
	task automatic test_wrap();
		set_limits(20, -1, 1023);
		for (int i = 0; i < 8; i++) send_char(i == 3 ? CODE_SPACE : 21'd97, 1, 4, 1, 0);
		send_char(21'd97, 1, 4, 0, 1);
		send_char(21'd98, 1, 30, 0, 0);
		send_char(21'd98, 1, 3, 0, 1);
	endtask

	// height stop and zero width limit
	task automatic test_height();
		set_limits(0, 0, 1);
		send_char(21'd97, 1, 0, 0, 0);
		send_char(CODE_NEWLINE, 1, 0, 0, 1);
		set_limits(65535, 28, 14);
		for (int i = 0; i < 4; i++) send_char(CODE_NEWLINE, 1, 1, 0, i == 3);
	endtask

	// long word after a space: space break, long rescan, then a width break
	task automatic test_rescan_overflow();
		set_limits(300, -1, 14);
		send_char(CODE_SPACE, 1, 1, 0, 0);
		for (int i = 0; i < 70; i++) send_char(21'd120, 1, 5, 0, i == 69);
	endtask

	// random texts under varied limits
	task automatic test_random();
		for (int t = 0; t < 24; t++) begin
			case (t % 4)
				0: set_limits(-1, -1, $urandom_range(1, 1023));
				1: set_limits($urandom_range(10, 60), -1, $urandom_range(1, 30));
				2: set_limits($urandom_range(5, 40), $urandom_range(20, 200),
					$urandom_range(1, 20));
				default: set_limits(-65536 + $urandom_range(0, 1), -65536, 1);
			endcase
			send_text($urandom_range(4, 20));
		end
	endtask

	// long receiver hold while the sender keeps going
	task automatic test_backpressure();
		set_limits(8, -1, 14);
		hold_cycles = 300;
		for (int i = 0; i < 30; i++) send_char(i % 2 ? CODE_NEWLINE : 21'd97, 1, 3, 0, i == 29);
		drain();
	endtask

	// receiver stall: long hold on request, else a drawn wait per result
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid) begin
				rx_wait <= stall_rand ? $urandom_range(0, 14) : 0;
			end
		end
	end

	// compare each line result with the oldest expectation
	always @(posedge clk) begin
		gtlw_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lines.size() == 0) begin
				$display("%0t unexpected line result exp=none act=%h", $realtime,
					{line_start, line_length, line_width, final_line, stopped_early,
					total_height, widest_line, buffer_overflow});
				fails++;
			end else begin
				e = expected_lines.pop_front();
				if ({line_start, line_length, line_width, final_line, stopped_early,
						total_height, widest_line, buffer_overflow} != e) begin
					$display("%0t line mismatch exp=%h act=%h", $realtime, e,
						{line_start, line_length, line_width, final_line, stopped_early,
						total_height, widest_line, buffer_overflow});
					fails++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("greedy_text_line_wrapper_top test failed");
		$finish;
	end

	initial begin
		fails = 0; hold_cycles = 0; rx_wait = 0; stall_rand = 0;
		lim_width = -1; lim_height = -1; lh = 14;
		clear_text();
		arst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; cfg_we = 1'b0;
		cfg_index = '0; cfg_data = '0; char_code = '0; has_glyph = 1'b0;
		advance = '0; pair_kerning = '0; last_char = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fields();
		stall_rand = 1;
		test_wrap();
		test_height();
		test_rescan_overflow();
		test_backpressure();
		test_random();
		drain();
		if (fails == 0 && expected_lines.size() == 0) begin
			$display("greedy_text_line_wrapper_top test passed");
		end else begin
			$display("greedy_text_line_wrapper_top test failed");
		end
		$finish;
	end
endmodule

// File: files.f
hdl/gtlw_pkg.sv
hdl/gtlw_ram.sv
hdl/gtlw_front.sv
hdl/gtlw_back.sv
hdl/greedy_text_line_wrapper_top.sv
tb/sv/tb_top.sv
